/* rtl/greedy_token_argmax_scorer_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the greedy token scorer checker.
// ---------------------------------------------------------------------------
`ifndef GREEDY_TOKEN_ARGMAX_SCORER_CORE_MACROS_SVH
`define GREEDY_TOKEN_ARGMAX_SCORER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GTAS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GTAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gtas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gtas_pkg
// Shared types, constants and tables of the greedy token scorer.
// ---------------------------------------------------------------------------
package gtas_pkg;

  localparam int MAX_VOCAB_DEF   = 8192;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_BLANK_PENALTY = 2'd0;
  localparam logic [1:0] REG_UNKNOWN_TOKEN = 2'd1;
  localparam logic [1:0] REG_INV_TEMP      = 2'd2;

  localparam logic [15:0] INV_TEMP_RESET = 16'd4096;

  // What the back end does with one element.
  typedef enum logic [1:0] {
    K_FIRST  = 2'd0,
    K_NEWMAX = 2'd1,
    K_OTHER  = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] blank_penalty;
    logic [12:0] unknown_token;
    logic [15:0] inv_temp;
  } cfg_t;

  // One queue entry between front and back.
  typedef struct packed {
    kind_t       kind;
    logic        dbig;   // distance at or above 16 in Q.10, exp is zero
    logic [13:0] d;
    logic        last;
    logic        emit;
    logic [12:0] token;
  } qentry_t;

  // Q.30 factor e^-(2^b/1024) for bit b of the distance.
  function automatic logic [29:0] exp_bit(input logic [3:0] b);
    logic [29:0] f;
    case (b)
      4'd0:    f = 30'd1072693760;
      4'd1:    f = 30'd1071646719;
      4'd2:    f = 30'd1069555701;
      4'd3:    f = 30'd1065385899;
      4'd4:    f = 30'd1057095000;
      4'd5:    f = 30'd1040706261;
      4'd6:    f = 30'd1008687096;
      4'd7:    f = 30'd947573834;
      4'd8:    f = 30'd836230973;
      4'd9:    f = 30'd651257337;
      4'd10:   f = 30'd395007542;
      4'd11:   f = 30'd145315154;
      4'd12:   f = 30'd19666268;
      4'd13:   f = 30'd360200;
      default: f = 30'd0;
    endcase
    return f;
  endfunction

  // Q.10 ln(1 + i/32).
  function automatic logic [9:0] ln_mant(input logic [5:0] i);
    logic [9:0] v;
    case (i)
      6'd0:  v = 10'd0;   6'd1:  v = 10'd32;  6'd2:  v = 10'd62;  6'd3:  v = 10'd92;
      6'd4:  v = 10'd121; 6'd5:  v = 10'd149; 6'd6:  v = 10'd176; 6'd7:  v = 10'd203;
      6'd8:  v = 10'd228; 6'd9:  v = 10'd254; 6'd10: v = 10'd278; 6'd11: v = 10'd303;
      6'd12: v = 10'd326; 6'd13: v = 10'd349; 6'd14: v = 10'd372; 6'd15: v = 10'd394;
      6'd16: v = 10'd415; 6'd17: v = 10'd436; 6'd18: v = 10'd457; 6'd19: v = 10'd477;
      6'd20: v = 10'd497; 6'd21: v = 10'd517; 6'd22: v = 10'd536; 6'd23: v = 10'd555;
      6'd24: v = 10'd573; 6'd25: v = 10'd591; 6'd26: v = 10'd609; 6'd27: v = 10'd626;
      6'd28: v = 10'd644; 6'd29: v = 10'd661; 6'd30: v = 10'd677; 6'd31: v = 10'd694;
      6'd32: v = 10'd710;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  // floor(x * inv / 4096).
  function automatic logic signed [22:0] scale(input logic signed [17:0] x,
                                               input logic [15:0] inv);
    logic signed [34:0] p;
    p = x * $signed({1'b0, inv});
    return p[34:12];
  endfunction

endpackage
`default_nettype wire

/* rtl/gtas_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gtas_queue
// Short register queue of decoded elements between front and back.
// ---------------------------------------------------------------------------
module gtas_queue #(
  parameter int DEPTH = gtas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  gtas_pkg::qentry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output gtas_pkg::qentry_t pop_data
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  gtas_pkg::qentry_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count updates.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

/* rtl/gtas_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gtas_front
// Accepts logits, tracks the argmax and decodes each element for the back.
// ---------------------------------------------------------------------------
module gtas_front #(
  parameter int MAX_VOCAB = gtas_pkg::MAX_VOCAB_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gtas_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_logit,
  input  logic              in_last,
  output logic              push_valid,
  input  logic              push_ready,
  output gtas_pkg::qentry_t push_data
);
  localparam int CW = $clog2(MAX_VOCAB + 1);
  localparam int IW = $clog2(MAX_VOCAB);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SCX  = 4'b0010,
    F_SCB  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [CW-1:0]        elem_r, elem_nxt;
  logic signed [17:0]   best_r, best_nxt;
  logic [IW-1:0]        bidx_r, bidx_nxt;
  logic signed [17:0]   x_r, bo_r;
  logic signed [22:0]   sx_r, sb_r;
  gtas_pkg::kind_t      kind_r, kind_nxt;
  logic                 last_r, emit_r, emit_nxt;
  logic [12:0]          tok_r, tok_nxt;

  logic                 accept, idx_ok;
  logic signed [17:0]   xp, mop;
  logic signed [22:0]   prod;
  logic signed [23:0]   span;
  logic [IW+12:0]       tok_ext;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = (elem_r < CW'(MAX_VOCAB));

  // Penalized logit: the blank entry loses the penalty.
  assign xp = $signed({{2{in_logit[15]}}, in_logit})
            - ((elem_r == '0) ? $signed({2'b00, cfg.blank_penalty}) : 18'sd0);

  // Argmax tracking and element decode at accept.
  always_comb begin
    elem_nxt = elem_r;
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    kind_nxt = gtas_pkg::K_NONE;
    if (idx_ok) begin
      elem_nxt = elem_r + 1'b1;
      if (elem_r == '0) begin
        kind_nxt = gtas_pkg::K_FIRST;
        best_nxt = xp;
        bidx_nxt = '0;
      end else if (xp > best_r) begin
        kind_nxt = gtas_pkg::K_NEWMAX;
        best_nxt = xp;
        bidx_nxt = elem_r[IW-1:0];
      end else begin
        kind_nxt = gtas_pkg::K_OTHER;
      end
    end
  end

  assign tok_ext  = {13'd0, bidx_nxt};
  assign tok_nxt  = tok_ext[12:0];
  assign emit_nxt = (bidx_nxt != '0) && ({13'd0, bidx_nxt} != {{IW{1'b0}}, cfg.unknown_token});

  // One shared multiplier scales the new logit, then the old best.
  assign mop  = (state_r == F_SCX) ? x_r : bo_r;
  assign prod = gtas_pkg::scale(mop, cfg.inv_temp);

  assign span = (kind_r == gtas_pkg::K_NEWMAX) ? (sx_r - sb_r) : (sb_r - sx_r);

  assign push_valid      = (state_r == F_PUSH);
  assign push_data.kind  = kind_r;
  assign push_data.dbig  = (span >= 24'sd16384);
  assign push_data.d     = span[13:0];
  assign push_data.last  = last_r;
  assign push_data.emit  = emit_r;
  assign push_data.token = tok_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_SCX;
      F_SCX:   state_nxt = F_SCB;
      F_SCB:   state_nxt = F_PUSH;
      F_PUSH:  if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      elem_r  <= '0;
      best_r  <= '0;
      bidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_last) begin
          elem_r <= '0;
          best_r <= '0;
          bidx_r <= '0;
        end else begin
          elem_r <= elem_nxt;
          best_r <= best_nxt;
          bidx_r <= bidx_nxt;
        end
      end
    end
  end

  // Element payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= xp;
      bo_r   <= best_r;
      kind_r <= kind_nxt;
      last_r <= in_last;
      emit_r <= emit_nxt;
      tok_r  <= tok_nxt;
    end
    if (state_r == F_SCX) begin
      sx_r <= prod;
    end
    if (state_r == F_SCB) begin
      sb_r <= prod;
    end
  end
endmodule
`default_nettype wire

/* rtl/gtas_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gtas_back
// Bit-serial exp, running sum, iterative ln and the frame result register.
// ---------------------------------------------------------------------------
module gtas_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  gtas_pkg::qentry_t pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_emitted,
  output logic [12:0]       out_token,
  output logic [31:0]       out_timestamp,
  output logic [15:0]       out_log_prob,
  output logic [15:0]       out_trailing
);
  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_EXP  = 6'b000010,
    B_SUM  = 6'b000100,
    B_NORM = 6'b001000,
    B_LN   = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_t;

  bstate_t state_r, state_nxt;

  gtas_pkg::qentry_t ent_r;
  logic [30:0] r_r;
  logic [3:0]  bit_r;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] q_r;
  logic [4:0]  k_r;
  logic [15:0] lnv_r;
  logic [31:0] fc_r;
  logic [15:0] br_r, br_nxt;
  logic        ov_r;

  logic [60:0] rmul;
  logic [30:0] r_step;
  logic [15:0] e_val;
  logic [47:0] smul;
  logic [32:0] resc, acc;
  logic [31:0] q_init;
  logic [5:0]  li;
  logic [9:0]  lo, hi;
  logic [25:0] kterm;
  logic [22:0] frac;
  logic [15:0] lnv;
  logic        take, can_load, needs_exp;

  assign pop_ready = (state_r == B_IDLE);
  assign take      = pop_valid && pop_ready;
  assign needs_exp = (pop_data.kind == gtas_pkg::K_NEWMAX)
                  || (pop_data.kind == gtas_pkg::K_OTHER);

  // One Q.30 factor per cycle, only for set distance bits.
  assign rmul   = r_r * gtas_pkg::exp_bit(bit_r);
  assign r_step = 31'((rmul + 61'd536870912) >> 30);

  // Sum update.
  assign e_val = 16'((32'(r_r) + 32'd16384) >> 15);
  assign smul  = sum_r * e_val;
  assign resc  = 33'((smul + 48'd16384) >> 15);
  always_comb begin
    acc     = '0;
    sum_nxt = sum_r;
    case (ent_r.kind)
      gtas_pkg::K_FIRST:  sum_nxt = 32'd32768;
      gtas_pkg::K_NEWMAX: begin
        acc     = resc + 33'd32768;
        sum_nxt = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      end
      gtas_pkg::K_OTHER:  begin
        acc     = {1'b0, sum_r} + {17'd0, e_val};
        sum_nxt = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      end
      default: sum_nxt = sum_r;
    endcase
  end
  assign q_init = (sum_nxt < 32'd32768) ? 32'd32768 : sum_nxt;

  // ln of the normalized sum: exponent term plus table interpolation.
  assign li    = {1'b0, q_r[30:26]};
  assign lo    = gtas_pkg::ln_mant(li);
  assign hi    = gtas_pkg::ln_mant(li + 6'd1);
  assign kterm = 26'((k_r * 21'd726817 + 26'd512) >> 10);
  assign frac  = 23'(((hi - lo) * q_r[25:10] + 32'd32768) >> 16);
  assign lnv   = kterm[15:0] + {6'd0, lo} + frac[15:0];

  assign can_load = !ov_r || out_ready;
  assign br_nxt   = ent_r.emit ? 16'd0 : ((br_r == 16'hFFFF) ? br_r : br_r + 1'b1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (take) begin
          state_nxt = (needs_exp && !pop_data.dbig) ? B_EXP : B_SUM;
        end
      end
      B_EXP:   if (bit_r == 4'd13) state_nxt = B_SUM;
      B_SUM:   state_nxt = ent_r.last ? B_NORM : B_IDLE;
      B_NORM:  if (q_r[31]) state_nxt = B_LN;
      B_LN:    state_nxt = B_OUT;
      B_OUT:   if (can_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state and running totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      sum_r   <= '0;
      fc_r    <= '0;
      br_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_SUM) begin
        sum_r <= sum_nxt;
      end
      if (state_r == B_OUT && can_load) begin
        ov_r  <= 1'b1;
        fc_r  <= fc_r + 1'b1;
        br_r  <= br_nxt;
        sum_r <= '0;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= pop_data;
      r_r   <= pop_data.dbig ? 31'd0 : 31'h4000_0000;
      bit_r <= '0;
    end
    if (state_r == B_EXP) begin
      if (ent_r.d[bit_r]) begin
        r_r <= r_step;
      end
      bit_r <= bit_r + 1'b1;
    end
    if (state_r == B_SUM) begin
      q_r <= q_init;
      k_r <= 5'd16;
    end
    if (state_r == B_NORM && !q_r[31]) begin
      q_r <= {q_r[30:0], 1'b0};
      k_r <= k_r - 1'b1;
    end
    if (state_r == B_LN) begin
      lnv_r <= lnv;
    end
    if (state_r == B_OUT && can_load) begin
      out_emitted   <= ent_r.emit;
      out_token     <= ent_r.token;
      out_timestamp <= fc_r;
      out_log_prob  <= ent_r.emit ? 16'(16'd0 - lnv_r) : 16'd0;
      out_trailing  <= br_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire

/* rtl/greedy_token_argmax_scorer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// greedy_token_argmax_scorer_core
// Greedy token choice with log-probability over one frame of streamed logits.
// ---------------------------------------------------------------------------
// The front end takes one logit word at a time and tracks the argmax; it
// takes no new word until the element is pushed to the queue. The back end
// runs a bit-serial exp on an element that needs one (one Q.30 multiply step
// for each of 14 distance bits) before the sum update, and goes straight to
// the sum update for the first element of a frame, for an element whose
// distance is too large for the exp and for an element past the vocabulary;
// at the frame end come the normalizing shift, ln and the result load, plus
// any result stall. The exp unit limits the sustained element rate; the queue
// between the two ends absorbs short bursts and output stalls. There is no clearing pass.
module greedy_token_argmax_scorer_core #(
  parameter int MAX_VOCAB   = gtas_pkg::MAX_VOCAB_DEF,
  parameter int QUEUE_DEPTH = gtas_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // logit[15:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // token[12:0], timestamp[44:13], log_prob[60:45], trailing_blanks[76:61], zero fill
  output logic [79:0] out_tdata,
  output logic        out_tuser   // emitted
);
  gtas_pkg::cfg_t    cfg_r;
  gtas_pkg::qentry_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop_ready;
  logic        o_emit;
  logic [12:0] o_token;
  logic [31:0] o_ts;
  logic [15:0] o_lp, o_tb;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blank_penalty <= '0;
      cfg_r.unknown_token <= '0;
      cfg_r.inv_temp      <= gtas_pkg::INV_TEMP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gtas_pkg::REG_BLANK_PENALTY: cfg_r.blank_penalty <= cfg_wdata;
        gtas_pkg::REG_UNKNOWN_TOKEN: cfg_r.unknown_token <= cfg_wdata[12:0];
        gtas_pkg::REG_INV_TEMP:      cfg_r.inv_temp      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gtas_front #(.MAX_VOCAB(MAX_VOCAB)) u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_logit(in_tdata), .in_last(in_tlast),
    .push_valid, .push_ready, .push_data
  );

  gtas_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push_valid, .push_ready, .push_data,
    .pop_valid, .pop_ready, .pop_data
  );

  gtas_back u_back (
    .clk, .rst_n, .pop_valid, .pop_ready, .pop_data,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_emitted(o_emit), .out_token(o_token), .out_timestamp(o_ts),
    .out_log_prob(o_lp), .out_trailing(o_tb)
  );

  assign out_tdata = {3'b000, o_tb, o_lp, o_ts, o_token};
  assign out_tuser = o_emit;
endmodule
`default_nettype wire

/* rtl/gtas_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gtas_checker
// Port-level checks on the result channel of the greedy token scorer.
// ---------------------------------------------------------------------------
`include "greedy_token_argmax_scorer_core_macros.svh"

module gtas_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [79:0] out_tdata,
  input wire        out_tuser
);
  // A stalled result word keeps its contents.
  `GTAS_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  // A frame without a token carries no log-probability.
  `GTAS_ASSERT_IMPL(a_nolp, clk, rst_n, out_tvalid && !out_tuser, out_tdata[60:45] == 16'd0, "log_prob set without emission")
  // An emitted token clears the trailing blank count.
  `GTAS_ASSERT_IMPL(a_tb, clk, rst_n, out_tvalid && out_tuser, out_tdata[76:61] == 16'd0, "trailing count not cleared")
  // A log-probability is never positive.
  `GTAS_ASSERT_IMPL(a_lpneg, clk, rst_n, out_tvalid && !out_tdata[60], out_tdata[60:45] == 16'd0, "positive log_prob")
endmodule

bind greedy_token_argmax_scorer_core gtas_checker u_gtas_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire

/* bench/greedy_token_argmax_scorer_core_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Greedy token scorer checker
// Watches the configuration port and both stream channels, predicts each
// frame's result from the accepted logit words, and compares in order.
// ---------------------------------------------------------------------------
module greedy_token_argmax_scorer_core_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // logit[15:0]
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // token[12:0], timestamp[44:13], log_prob[60:45], trailing_blanks[76:61]
  input  logic [79:0] out_tdata,
  input  logic        out_tuser,  // emitted
  output int          fail_count,
  output int          pending,
  output int          frames_seen
);
  localparam int VOCAB = 8192;

  typedef struct {
    logic        emitted;
    logic [12:0] token;
    logic [31:0] timestamp;
    logic [15:0] log_prob;
    logic [15:0] trailing_blanks;
  } frame_result_t;

  // Q.30 factors e^-(2^b/1024).
  localparam longint unsigned EXP_FACTOR [14] = '{
    1072693760, 1071646719, 1069555701, 1065385899, 1057095000,
    1040706261, 1008687096, 947573834, 836230973, 651257337,
    395007542, 145315154, 19666268, 360200
  };

  // Q.10 ln(1 + i/32).
  localparam int unsigned LN_TABLE [33] = '{
    0, 32, 62, 92, 121, 149, 176, 203, 228, 254, 278, 303, 326, 349, 372,
    394, 415, 436, 457, 477, 497, 517, 536, 555, 573, 591, 609, 626, 644,
    661, 677, 694, 710
  };

  frame_result_t result_q[$];

  logic [15:0] penalty;
  logic [12:0] unk_id;
  logic [15:0] inv_temp;

  int unsigned elem_idx;
  int          best_val;
  int unsigned best_idx;
  int unsigned sum_q15;
  logic [31:0] frame_no;
  int unsigned blank_count;

  assign pending = result_q.size();

  // Temperature scaling, rounded toward minus infinity.
  function automatic int temp_scale(input int x, input logic [15:0] inv);
    longint p;
    p = longint'(x) * longint'({16'd0, inv});
    return int'(p >>> 12);
  endfunction

  // exp(-d/1024) in Q.15.
  function automatic longint unsigned exp_q15(input int unsigned d);
    longint unsigned r;
    r = 64'd1 << 30;
    if (d >= 16384) return 0;
    for (int b = 0; b < 14; b++)
      if (d[b]) r = (r * EXP_FACTOR[b] + (64'd1 << 29)) >> 30;
    return (r + (64'd1 << 14)) >> 15;
  endfunction

  function automatic int unsigned sat_add(input int unsigned s, input longint unsigned v);
    longint unsigned t;
    t = longint'(s) + v;
    return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : int'(t);
  endfunction

  // ln(sum / 32768) in Q.10.
  function automatic int unsigned ln_q10(input int unsigned s);
    int msb;
    int unsigned k, q, i, r, lo, hi;
    logic [31:0] sv;
    msb = 31;
    sv = (s < 32768) ? 32'd32768 : s;
    while (msb > 0 && !sv[msb]) msb--;
    k = msb - 15;
    q = sv << (31 - msb);
    i = (q >> 26) & 31;
    r = (q >> 10) & 16'hFFFF;
    lo = LN_TABLE[i];
    hi = LN_TABLE[i + 1];
    return ((k * 726817 + 512) >> 10) + lo + (((hi - lo) * r + 32768) >> 16);
  endfunction

  // Prediction of each accepted logit word.
  task automatic score_word(input logic [15:0] raw, input logic is_last);
    int x, m_old, m_new, lp;
    longint unsigned e;
    logic emit;
    frame_result_t res;
    x = int'($signed(raw));
    if (elem_idx < VOCAB) begin
      if (elem_idx == 0) begin
        best_val = x - int'(penalty);
        best_idx = 0;
        sum_q15 = 32768;
      end else if (x > best_val) begin
        m_old = temp_scale(best_val, inv_temp);
        m_new = temp_scale(x, inv_temp);
        e = exp_q15(m_new - m_old);
        sum_q15 = int'((longint'(sum_q15) * e + 16384) >> 15);
        sum_q15 = sat_add(sum_q15, 32768);
        best_val = x;
        best_idx = elem_idx;
      end else begin
        m_old = temp_scale(best_val, inv_temp);
        m_new = temp_scale(x, inv_temp);
        sum_q15 = sat_add(sum_q15, exp_q15(m_old - m_new));
      end
      elem_idx++;
    end
    if (is_last) begin
      emit = (best_idx != 0) && (best_idx[12:0] != unk_id);
      lp = 0;
      if (emit) begin
        lp = -int'(ln_q10(sum_q15));
        if (lp < -32768) lp = -32768;
        blank_count = 0;
      end else if (blank_count < 65535) begin
        blank_count++;
      end
      res.emitted = emit;
      res.token = best_idx[12:0];
      res.timestamp = frame_no;
      res.log_prob = lp[15:0];
      res.trailing_blanks = blank_count[15:0];
      result_q.insert(result_q.size(), res);
      frame_no++;
      elem_idx = 0;
      best_val = 0;
      best_idx = 0;
      sum_q15 = 0;
    end
  endtask

  task automatic note_mismatch(input string fld, input longint unsigned want,
                               input longint unsigned got);
    if (fail_count < 10)
      $display("mismatch at frame result: %s expected %0h got %0h", fld, want, got);
    fail_count++;
  endtask

  // Watch all ports at the rising edge.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      penalty = 16'd0;
      unk_id = 13'd0;
      inv_temp = gtas_pkg::INV_TEMP_RESET;
      elem_idx = 0;
      best_val = 0;
      best_idx = 0;
      sum_q15 = 0;
      frame_no = 32'd0;
      blank_count = 0;
      fail_count = 0;
      frames_seen = 0;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gtas_pkg::REG_BLANK_PENALTY: penalty = cfg_wdata;
          gtas_pkg::REG_UNKNOWN_TOKEN: unk_id = cfg_wdata[12:0];
          gtas_pkg::REG_INV_TEMP:      inv_temp = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        frames_seen++;
        if (result_q.size() == 0) begin
          note_mismatch("unexpected result word, token", 0, out_tdata[12:0]);
        end else begin
          want = result_q.pop_front();
          if (out_tuser !== want.emitted)
            note_mismatch("emitted", want.emitted, out_tuser);
          if (out_tdata[12:0] !== want.token)
            note_mismatch("token", want.token, out_tdata[12:0]);
          if (out_tdata[44:13] !== want.timestamp)
            note_mismatch("timestamp", want.timestamp, out_tdata[44:13]);
          if (out_tdata[60:45] !== want.log_prob)
            note_mismatch("log_prob", want.log_prob, out_tdata[60:45]);
          if (out_tdata[76:61] !== want.trailing_blanks)
            note_mismatch("trailing_blanks", want.trailing_blanks, out_tdata[76:61]);
        end
      end
      if (in_tvalid && in_tready)
        score_word(in_tdata, in_tlast);
    end
  end

  // Results still owed at the end count as failures.
  task automatic flag_leftovers();
    if (result_q.size() != 0) begin
      $display("%0d expected results never arrived", result_q.size());
      fail_count += result_q.size();
    end
  endtask

endmodule

/* bench/greedy_token_argmax_scorer_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Greedy token scorer testbench
// Streams directed and random logit frames through four flow-control phases,
// each under its own register setting, and leaves checking to the checker.
// ---------------------------------------------------------------------------
module greedy_token_argmax_scorer_core_tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = gtas_pkg::REG_BLANK_PENALTY;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;   // logit[15:0]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // token[12:0], timestamp[44:13], log_prob[60:45], trailing_blanks[76:61]
  logic [79:0] out_tdata;
  logic        out_tuser;          // emitted

  int fail_count, pending, frames_seen;
  int send_gap_pct, stall_pct;
  int cycles;
  int words_sent;
  logic word_taken;

  always #2 clk = ~clk;

  greedy_token_argmax_scorer_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  greedy_token_argmax_scorer_core_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending), .frames_seen(frames_seen)
  );

  // Acceptance flag, sampled at the rising edge and read at the falling one.
  always @(posedge clk) word_taken <= in_tvalid && in_tready;

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk) out_tready <= rst_n && ($urandom_range(99) >= stall_pct);

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Sends one logit word; called at a falling edge, returns at one.
  task automatic send_word(input logic [15:0] logit, input logic is_last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = logit;
    in_tlast = is_last;
    do @(negedge clk); while (!word_taken);
    in_tvalid = 1'b0;
    words_sent++;
  endtask

  // Waits for the block to go idle, then writes one register.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One random frame; near-equal logits exercise the exp and ln paths.
  task automatic random_frame();
    int len, base;
    logic [15:0] v;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
    base = $urandom_range(65535);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(1)) v = $urandom_range(65535);
      else v = base[15:0] + 16'($urandom_range(3000)) - 16'd1500;
      send_word(v, i == len - 1);
    end
  endtask

  initial begin
    logic [15:0] pen_set [4];
    logic [15:0] unk_set [4];
    logic [15:0] inv_set [4];
    int gap_set [4];
    int stall_set [4];
    int target;
    pen_set = '{16'd0, 16'd65535, 16'd300, 16'd1024};
    unk_set = '{16'd0, 16'd8191, 16'd3, 16'd2};
    inv_set = '{16'd4096, 16'd65535, 16'd1, 16'd0};
    gap_set = '{0, 79, 0, 8};
    stall_set = '{0, 0, 79, 8};
    cycles = 0;
    words_sent = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed frames under reset settings: lone blank, extremes, ties.
    send_word(16'h0000, 1'b1);
    send_word(16'h8000, 1'b0);
    send_word(16'h7FFF, 1'b1);
    send_word(16'd5, 1'b0);
    send_word(16'd5, 1'b0);
    send_word(16'd5, 1'b1);
    send_word(16'h8000, 1'b0);
    send_word(16'd100, 1'b0);
    send_word(16'd100, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h7FFF, 1'b1);
    send_word(16'hFC00, 1'b0);
    send_word(16'd0, 1'b1);

    // Phases of flow control, each with its own register setting.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(gtas_pkg::REG_BLANK_PENALTY, pen_set[ph]);
      write_reg(gtas_pkg::REG_UNKNOWN_TOKEN, unk_set[ph]);
      write_reg(gtas_pkg::REG_INV_TEMP, inv_set[ph]);
      send_gap_pct = gap_set[ph];
      stall_pct = stall_set[ph];
      // A top blank logit under the phase's blank penalty, then three rising logits.
      send_word(16'h7FFF, 1'b0);
      for (int i = 1; i < 4; i++) send_word(16'h7000 + 16'(i), i == 3);
      target = words_sent + 220;
      while (words_sent < target) random_frame();
    end

    send_gap_pct = 0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    chk.flag_leftovers();
    $display("sent %0d logit words, checked %0d frame results", words_sent, frames_seen);
    $display("covered four flow-control phases and four register settings");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/gtas_pkg.sv
rtl/gtas_queue.sv
rtl/gtas_front.sv
rtl/gtas_back.sv
rtl/greedy_token_argmax_scorer_core.sv
rtl/gtas_checker.sv
bench/greedy_token_argmax_scorer_core_checker.sv
bench/greedy_token_argmax_scorer_core_tb.sv
